// ===== design/pgm_pkg.sv =====
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared types and constants for the pulse glitch merge and rate limit core.
// ----------------------------------------------------------------------------
package pgm_pkg;

  localparam int DUR_W      = 32;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_W-1:0] GLITCH_THRESHOLD_RESET = CFG_W'(30);
  localparam logic [CFG_W-1:0] RATE_LIMIT_RESET       = CFG_W'(30);

  // Register indexes as decoded from paddr[2].
  typedef enum logic {
    REG_GLITCH_THRESHOLD = 1'b0,
    REG_RATE_LIMIT       = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_PULSE   = 1'b0,
    OP_OVERRUN = 1'b1
  } op_t;

  typedef enum logic {
    KIND_PULSE   = 1'b0,
    KIND_OVERRUN = 1'b1
  } kind_t;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    op_t               op;
    logic              glitch;
    logic              level;
    logic [DUR_W-1:0]  duration;
    logic [TIME_W-1:0] now_ms;
  } item_t;

endpackage

// ===== design/pgm_front.sv =====
// ----------------------------------------------------------------------------
// pgm_front
// Holds the configuration registers behind the APB port and classifies each
// incoming item as an overrun marker, a glitch or an ordinary pulse.
// ----------------------------------------------------------------------------
module pgm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pgm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pgm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pgm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_cmd,
  input  logic                           in_level,
  input  logic [pgm_pkg::DUR_W-1:0]      in_duration,
  input  logic [pgm_pkg::TIME_W-1:0]     in_now_ms,
  output pgm_pkg::item_t                 item,
  output logic [pgm_pkg::CFG_W-1:0]      rate_limit_ms
);
  import pgm_pkg::*;

  logic [CFG_W-1:0] glitch_threshold_us;
  logic             wr_en;
  reg_idx_t         wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_threshold_us <= GLITCH_THRESHOLD_RESET;
      rate_limit_ms       <= RATE_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_GLITCH_THRESHOLD: glitch_threshold_us <= pwdata[CFG_W-1:0];
        REG_RATE_LIMIT:       rate_limit_ms       <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_GLITCH_THRESHOLD: prdata = APB_DATA_W'(glitch_threshold_us);
      REG_RATE_LIMIT:       prdata = APB_DATA_W'(rate_limit_ms);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    item.op       = op_t'(in_cmd);
    item.glitch   = in_duration < DUR_W'(glitch_threshold_us);
    item.level    = in_level;
    item.duration = in_duration;
    item.now_ms   = in_now_ms;
  end

endmodule

// ===== design/pgm_queue.sv =====
// ----------------------------------------------------------------------------
// pgm_queue
// Short first-in first-out queue of classified items between the front and
// the back part.
// ----------------------------------------------------------------------------
module pgm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pgm_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output pgm_pkg::item_t head_item
);
  import pgm_pkg::*;

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push && !full) - QCNT_W'(pop && head_valid);
    end
  end

endmodule

// ===== design/pgm_back.sv =====
// ----------------------------------------------------------------------------
// pgm_back
// Keeps the pending pulse and the last emission time, merges or closes pulses
// and drives the registered result stream.
// ----------------------------------------------------------------------------
module pgm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  pgm_pkg::item_t              head_item,
  output logic                        pop,
  input  logic [pgm_pkg::CFG_W-1:0]   rate_limit_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic                        out_level,
  output logic [pgm_pkg::DUR_W-1:0]   out_duration
);
  import pgm_pkg::*;

  logic               pending_level;
  logic [DUR_W-1:0]   pending_duration;
  logic [TIME_W-1:0]  last_emit_ms;

  logic               is_overrun;
  logic               merge;
  logic               emit;
  logic [DUR_W:0]     sum;
  logic [DUR_W-1:0]   merged_duration;
  logic [TIME_W-1:0]  elapsed;

  // The result register is free when empty or when its transfer happens now.
  assign pop        = head_valid && (!out_valid || out_ready);
  assign is_overrun = head_item.op == OP_OVERRUN;
  assign merge      = !is_overrun && (head_item.glitch || head_item.level == pending_level);
  assign sum        = {1'b0, pending_duration} + {1'b0, head_item.duration};
  assign merged_duration = sum[DUR_W] ? '1 : sum[DUR_W-1:0];
  assign elapsed    = head_item.now_ms - last_emit_ms;
  assign emit       = !is_overrun && !merge && elapsed >= TIME_W'(rate_limit_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_level    <= 1'b0;
      pending_duration <= '0;
      last_emit_ms     <= '0;
    end else if (pop && !is_overrun) begin
      if (merge) begin
        pending_duration <= merged_duration;
      end else begin
        pending_level    <= head_item.level;
        pending_duration <= head_item.duration;
        if (emit) begin
          last_emit_ms <= head_item.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= is_overrun || emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (is_overrun) begin
        out_kind     <= KIND_OVERRUN;
        out_level    <= 1'b0;
        out_duration <= '0;
      end else begin
        out_kind     <= KIND_PULSE;
        out_level    <= pending_level;
        out_duration <= pending_duration;
      end
    end
  end

  a_overrun_result : assert property (@(posedge clk) disable iff (rst)
    pop && is_overrun |=> out_valid && out_kind == KIND_OVERRUN && out_duration == '0)
    else $error("overrun marker did not produce an overrun notice");

  a_merge_keeps_level : assert property (@(posedge clk) disable iff (rst)
    pop && merge |=> $stable(pending_level) && $stable(last_emit_ms))
    else $error("merge changed the pending level or the emission time");

  a_merge_grows : assert property (@(posedge clk) disable iff (rst)
    pop && merge |=> pending_duration >= $past(pending_duration))
    else $error("merged duration shrank");

  a_emit_time : assert property (@(posedge clk) disable iff (rst)
    pop && emit |=> last_emit_ms == $past(head_item.now_ms) && out_valid)
    else $error("emission did not record its timestamp");

endmodule

// ===== design/pulse_glitch_merge_rate_limit_core.sv =====
// ----------------------------------------------------------------------------
// pulse_glitch_merge_rate_limit_core
// Pulse glitch filter: merges short or same-level pulses, emits closed pulses
// subject to a minimum gap in milliseconds, and forwards overrun notices.
// ----------------------------------------------------------------------------
// Path: an input transfer is written into the queue, and its result is
// registered in the result register when the back part pops the queue head.
// Throughput: one item per cycle while m_axis is not stalled, set by the merge/close step in
// the back part; a two-entry queue lets the input run while a result stalls.
// Reset (rst, synchronous) clears the pending pulse, the emission time, the
// queue and the result valid flag, and restores both thresholds to 30.
module pulse_glitch_merge_rate_limit_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pgm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pgm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pgm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] pulse_level, [32:1] pulse_duration_us, [64:33] now_ms, rest zero
  input  logic [pgm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] cmd
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] out_level, [32:1] out_duration_us, rest zero
  output logic [pgm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [0] kind
  output logic                            m_axis_tuser
);
  import pgm_pkg::*;

  item_t             front_item;
  item_t             head_item;
  logic              q_full;
  logic              head_valid;
  logic              pop;
  logic [CFG_W-1:0]  rate_limit_ms;
  logic              out_level;
  logic [DUR_W-1:0]  out_duration;

  assign s_axis_tready = !q_full;

  pgm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_cmd       (s_axis_tuser),
    .in_level     (s_axis_tdata[0]),
    .in_duration  (s_axis_tdata[DUR_W:1]),
    .in_now_ms    (s_axis_tdata[DUR_W+TIME_W:DUR_W+1]),
    .item         (front_item),
    .rate_limit_ms(rate_limit_ms)
  );

  pgm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_item (head_item)
  );

  pgm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .rate_limit_ms(rate_limit_ms),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_kind     (m_axis_tuser),
    .out_level    (out_level),
    .out_duration (out_duration)
  );

  assign m_axis_tdata = {(OUT_DATA_W - DUR_W - 1)'(0), out_duration, out_level};

endmodule
